@@ rtl/core/pmpre_pkg.sv @@
// ----------------------------------------------------------------------------
// pmpre_pkg: shared types and constants of the PMP region encoder
// Entry modes, config byte layout and field widths.
// ----------------------------------------------------------------------------
package pmpre_pkg;

  localparam int unsigned GRAIN_W   = 6;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned INDEX_W   = 6;
  localparam int unsigned ENTRY_W   = CFG_W + ADDR_W;
  localparam logic [GRAIN_W-1:0] GRAIN_RESET = 6'd2;
  localparam logic [GRAIN_W-1:0] GRAIN_MIN   = 6'd2;
  localparam logic [GRAIN_W-1:0] GRAIN_FULL  = 6'd32;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_TOR   = 2'd1,
    MODE_NA4   = 2'd2,
    MODE_NAPOT = 2'd3
  } pmp_mode_e;

  // bit0 R (always), bit1 W, bit2 X, bits4:3 mode
  function automatic logic [CFG_W-1:0] make_cfg(logic w, logic x, pmp_mode_e mode);
    make_cfg = {3'b000, mode, x, w, 1'b1};
  endfunction

endpackage

@@ rtl/core/pmpre_if.sv @@
// ----------------------------------------------------------------------------
// pmpre_if: valid/ready channels of the PMP region encoder
// Region words in, protection entry words out.
// ----------------------------------------------------------------------------
interface pmpre_region_if;
  import pmpre_pkg::*;

  logic              valid;
  logic              ready;
  logic              carries_region;
  logic [ADDR_W-1:0] region_base;
  logic [ADDR_W-1:0] region_size;
  logic              allow_write;
  logic              allow_exec;
  logic              last_region;

  modport source (output valid, carries_region, region_base, region_size,
                  allow_write, allow_exec, last_region, input ready);
  modport sink   (input valid, carries_region, region_base, region_size,
                  allow_write, allow_exec, last_region, output ready);
endinterface

interface pmpre_entry_if;
  import pmpre_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] entry_index;
  logic [CFG_W-1:0]   entry_config;
  logic [ADDR_W-1:0]  entry_address;
  logic               success;
  logic               last_entry;

  modport source (output valid, entry_index, entry_config, entry_address,
                  success, last_entry, input ready);
  modport sink   (input valid, entry_index, entry_config, entry_address,
                  success, last_entry, output ready);
endinterface

@@ rtl/core/pmp_region_encoder.sv @@
// ----------------------------------------------------------------------------
// pmp_region_encoder: region map to staged RISC-V PMP entry table
// Encodes regions as NA4, NAPOT or TOR (with a base entry unless it adjoins the previous region) and emits the table.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake       | word
//  ----------+-----+-----------------+-----------------------------------------
//  region_i  | in  | valid/ready     | carries_region, base, size, W, X, last
//  entry_o   | out | valid/ready     | index, config, address, success, last
//  cfg_*_i   | in  | write enable    | grain_log2 (6 bits), no read-back
//
//  A region word goes through IDLE (accept) and EVAL (write), and through WR2 when a TOR
//  entry needs its own base entry: the single RAM write port takes one entry
//  per cycle. On the last region the table goes out one entry at a time through RD
//  (RAM read), LD (output load) and WAIT (handshake, held for any stall on entry_o); a failed
//  map gives one word. region_i.ready is high only in IDLE.
//  Reset clears control state only; the table RAM is not cleared, entries
//  beyond the fill count are sent as config 0, address 0.
//
module pmp_region_encoder #(
  parameter int unsigned ENTRY_COUNT = 16,
  parameter int unsigned FIRST_ENTRY = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pmpre_pkg::GRAIN_W-1:0]    cfg_wdata_i,
  pmpre_region_if.sink                     region_i,
  pmpre_entry_if.source                    entry_o
);
  import pmpre_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRY_COUNT);
  localparam int unsigned CNT_W = $clog2(ENTRY_COUNT + 1);
  localparam logic [CNT_W-1:0] CNT_FULL     = CNT_W'(ENTRY_COUNT);
  localparam logic [CNT_W-1:0] CNT_TWO_LEFT = CNT_W'(ENTRY_COUNT - 2);
  localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(ENTRY_COUNT - 1);
  // previous end after clear: all ones when the range does not start at 0
  localparam logic [ADDR_W:0]  PREV_CLEAR   = (FIRST_ENTRY != 0) ? '1 : '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WR2,
    ST_RD,
    ST_LD,
    ST_WAIT
  } state_e;

  state_e             state_q;
  logic [GRAIN_W-1:0] grain_q;
  logic [CNT_W-1:0]   used_q;
  logic [ADDR_W:0]    prev_end_q;
  logic               failed_q;
  logic [IDX_W-1:0]   emit_idx_q;

  // captured region word
  logic               carries_q;
  logic [ADDR_W-1:0]  base_q;
  logic [ADDR_W-1:0]  size_q;
  logic               wr_q;
  logic               ex_q;
  logic               last_q;

  // second (TOR) entry pending after a base entry
  logic [ENTRY_W-1:0] tor_data_q;

  // output register
  logic               out_valid_q;
  logic [INDEX_W-1:0] out_index_q;
  logic [CFG_W-1:0]   out_cfg_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic               out_success_q;
  logic               out_last_q;

  // ---------------------------------------------------------------- decode
  logic [GRAIN_W-1:0] grain_eff;
  logic [ADDR_W-1:0]  grain_mask;
  logic               misaligned;
  logic               full;
  logic [ADDR_W:0]    end_addr;
  logic               adjoins;
  logic               size_pow2;
  logic               is_na4;
  logic               is_napot;
  logic               need_base;
  logic               no_room_base;
  logic               fail_now;
  logic               add_ok;
  logic [ENTRY_W-1:0] tor_data;
  logic [ENTRY_W-1:0] first_data;

  always_comb begin
    grain_eff  = (grain_q < GRAIN_MIN) ? GRAIN_MIN : grain_q;
    grain_mask = (grain_eff >= GRAIN_FULL) ? '1
               : ((ADDR_W'(1) << grain_eff[4:0]) - ADDR_W'(1));
    misaligned = |((base_q | size_q) & grain_mask);
    full       = (used_q >= CNT_FULL);
    end_addr   = {1'b0, base_q} + {1'b0, size_q};
    adjoins    = ({1'b0, base_q} == prev_end_q);
    size_pow2  = ((size_q & (size_q - ADDR_W'(1))) == '0);
    is_na4     = !adjoins && (size_q == ADDR_W'(4));
    is_napot   = !adjoins && (size_q >= ADDR_W'(8)) && size_pow2
              && ((base_q & (size_q - ADDR_W'(1))) == '0);
    need_base  = !adjoins && !is_na4 && !is_napot;
    no_room_base = need_base && (used_q > CNT_TWO_LEFT);
    fail_now   = carries_q && !failed_q && (misaligned || full || no_room_base);
    add_ok     = carries_q && !failed_q && !fail_now;

    // 33-bit end shifted right by two fills the low 31 address bits
    tor_data   = {make_cfg(wr_q, ex_q, MODE_TOR), 1'b0, end_addr[ADDR_W:2]};
    if (is_na4) begin
      first_data = {make_cfg(wr_q, ex_q, MODE_NA4), 2'b00, base_q[ADDR_W-1:2]};
    end else if (is_napot) begin
      first_data = {make_cfg(wr_q, ex_q, MODE_NAPOT),
                    {2'b00, base_q[ADDR_W-1:2]} | ((size_q >> 3) - ADDR_W'(1))};
    end else if (need_base) begin
      first_data = {CFG_W'(0), 2'b00, base_q[ADDR_W-1:2]};
    end else begin
      first_data = tor_data;
    end
  end

  // ---------------------------------------------------------------- table RAM
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = first_data;
    unique case (state_q)
      ST_EVAL: ram_we = add_ok;
      ST_WR2: begin
        ram_we    = 1'b1;
        ram_wdata = tor_data_q;
      end
      default: ram_we = 1'b0;
    endcase
    ram_waddr = used_q[IDX_W-1:0];
    ram_re    = (state_q == ST_RD);
  end

  pmpre_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRY_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (emit_idx_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- control
  logic emit_used;
  assign emit_used = (CNT_W'(emit_idx_q) < used_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      grain_q       <= GRAIN_RESET;
      used_q        <= '0;
      prev_end_q    <= PREV_CLEAR;
      failed_q      <= 1'b0;
      emit_idx_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        grain_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (region_i.valid) begin
            carries_q <= region_i.carries_region;
            base_q    <= region_i.region_base;
            size_q    <= region_i.region_size;
            wr_q      <= region_i.allow_write;
            ex_q      <= region_i.allow_exec;
            last_q    <= region_i.last_region;
            state_q   <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (fail_now) begin
            failed_q <= 1'b1;
          end
          if (add_ok) begin
            prev_end_q <= end_addr;
            used_q     <= used_q + CNT_W'(1);
            tor_data_q <= tor_data;
          end
          emit_idx_q <= '0;
          if (add_ok && need_base) begin
            state_q <= ST_WR2;
          end else if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (failed_q || fail_now) begin
            // failed map: one rejection word
            out_valid_q   <= 1'b1;
            out_index_q   <= '0;
            out_cfg_q     <= '0;
            out_addr_q    <= '0;
            out_success_q <= 1'b0;
            out_last_q    <= 1'b1;
            state_q       <= ST_WAIT;
          end else begin
            state_q <= ST_RD;
          end
        end
        ST_WR2: begin
          used_q  <= used_q + CNT_W'(1);
          state_q <= last_q ? ST_RD : ST_IDLE;
        end
        ST_RD: begin
          state_q <= ST_LD;
        end
        ST_LD: begin
          out_valid_q   <= 1'b1;
          out_index_q   <= INDEX_W'(emit_idx_q);
          out_cfg_q     <= emit_used ? ram_rdata[ENTRY_W-1:ADDR_W] : '0;
          out_addr_q    <= emit_used ? ram_rdata[ADDR_W-1:0] : '0;
          out_success_q <= 1'b1;
          out_last_q    <= (emit_idx_q == IDX_LAST);
          state_q       <= ST_WAIT;
        end
        ST_WAIT: begin
          if (entry_o.ready) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              // map done: back to an empty map
              used_q     <= '0;
              prev_end_q <= PREV_CLEAR;
              failed_q   <= 1'b0;
              state_q    <= ST_IDLE;
            end else begin
              emit_idx_q <= emit_idx_q + IDX_W'(1);
              state_q    <= ST_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign region_i.ready      = (state_q == ST_IDLE);
  assign entry_o.valid         = out_valid_q;
  assign entry_o.entry_index   = out_index_q;
  assign entry_o.entry_config  = out_cfg_q;
  assign entry_o.entry_address = out_addr_q;
  assign entry_o.success       = out_success_q;
  assign entry_o.last_entry    = out_last_q;

endmodule

@@ rtl/core/pmpre_ram.sv @@
// ----------------------------------------------------------------------------
// pmpre_ram: generic simple dual-port RAM
// One write port, one read port, registered read data held without read.
// ----------------------------------------------------------------------------
module pmpre_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
